/* design/sftp_pkg.sv */
// Shared types and constants for the serial transmit FIFO packetizer.
// No dependencies; every other file of the block imports this package.
package sftp_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 7;

  localparam int unsigned FIFO_DEPTH_DEF = 256;
  localparam int unsigned PACKET_MAX_DEF = 64;

  // Depth of the command queue between front and back (power of two).
  localparam int unsigned CMDQ_DEPTH = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH    = 2'd0,
    MODE_SERVICE = 2'd1,
    MODE_DONE    = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_SERVICE = 2'd1,
    CMD_DONE    = 2'd2
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e         kind;
    logic [BYTE_W-1:0] data;
  } cmd_t;

endpackage

/* design/sftp_if.sv */
// Valid/ready channel interfaces for input items and packet bytes.
// Depends on sftp_pkg for field widths.
interface sftp_in_if;
  import sftp_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [BYTE_W-1:0] data_byte;
  logic              link_configured;

  modport source(output valid, mode, data_byte, link_configured, input ready);
  modport sink(input valid, mode, data_byte, link_configured, output ready);
endinterface

interface sftp_out_if;
  import sftp_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_out;
  logic [LEN_W-1:0]  packet_length;
  logic              last;

  modport source(output valid, byte_out, packet_length, last, input ready);
  modport sink(input valid, byte_out, packet_length, last, output ready);
endinterface

/* design/sftp_front.sv */
// Front end: accept input items and turn them into back-end commands.
// Depends on sftp_pkg and sftp_in_if.
module sftp_front (
  sftp_in_if.sink       in_ch,
  output sftp_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import sftp_pkg::*;

  logic keep;

  // Drop unlinked pushes and the unused mode code here; they change nothing.
  always_comb begin
    keep       = 1'b0;
    cmd_o.kind = CMD_DONE;
    cmd_o.data = in_ch.data_byte;
    unique case (in_ch.mode)
      MODE_PUSH: begin
        keep       = in_ch.link_configured;
        cmd_o.kind = CMD_PUSH;
      end
      MODE_SERVICE: begin
        keep       = 1'b1;
        cmd_o.kind = CMD_SERVICE;
      end
      MODE_DONE: begin
        keep       = 1'b1;
        cmd_o.kind = CMD_DONE;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = cmd_ready_i;
  assign cmd_valid_o = in_ch.valid && keep;

endmodule

/* design/sftp_cmd_queue.sv */
// Short command queue that decouples the front end from the back end.
// Depends on sftp_pkg for the command type and queue depth.
module sftp_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sftp_pkg::cmd_t wr_cmd_i,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  output sftp_pkg::cmd_t rd_cmd_o,
  output logic           rd_valid_o,
  input  logic           rd_ready_i
);
  import sftp_pkg::*;

  localparam int unsigned PW = $clog2(CMDQ_DEPTH);
  localparam int unsigned CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          entry_q [CMDQ_DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign wr_ready_o = (cnt_q != CW'(CMDQ_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_cmd_o   = entry_q[rptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d = push ? wptr_q + 1'b1 : wptr_q;
    rptr_d = pop ? rptr_q + 1'b1 : rptr_q;
    cnt_d  = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wptr_q] <= wr_cmd_i;
    end
  end

endmodule

/* design/sftp_back.sv */
// Back end: byte store, read/write indexes, busy flag and packet drain.
// Depends on sftp_pkg and sftp_out_if.
module sftp_back #(
  parameter int unsigned FIFO_DEPTH = sftp_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned PACKET_MAX = sftp_pkg::PACKET_MAX_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sftp_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  sftp_out_if.source     out_ch
);
  import sftp_pkg::*;

  localparam int unsigned AW = $clog2(FIFO_DEPTH);
  localparam int unsigned RW = (AW + 1 > LEN_W) ? AW + 1 : LEN_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(FIFO_DEPTH - 1);

  logic [BYTE_W-1:0] mem_q [FIFO_DEPTH];

  logic [AW-1:0]     widx_q, widx_d, ridx_q, ridx_d, raddr_q, raddr_d;
  logic              busy_q, busy_d;
  logic [LEN_W-1:0]  remain_q, remain_d, len_q, len_d;
  logic              rd_v_q, rd_v_d, rd_last_q;
  logic [LEN_W-1:0]  rd_len_q;
  logic [BYTE_W-1:0] rd_data_q;
  logic              out_v_q, out_v_d, out_last_q;
  logic [LEN_W-1:0]  out_len_q;
  logic [BYTE_W-1:0] out_byte_q;

  logic              cmd_pop, do_push, start, issue, rd_move, out_fire;
  logic [RW-1:0]     run_full, run_cap, ridx_sum;

  assign cmd_ready_o = (remain_q == '0);
  assign cmd_pop     = cmd_valid_i && cmd_ready_o;
  assign do_push     = cmd_pop && (cmd_i.kind == CMD_PUSH);

  // Contiguous run to write index or store end on wrap, at most PACKET_MAX.
  always_comb begin
    if (ridx_q > widx_q) begin
      run_full = RW'(FIFO_DEPTH) - RW'(ridx_q);
    end else begin
      run_full = RW'(widx_q) - RW'(ridx_q);
    end
    run_cap  = (run_full > RW'(PACKET_MAX)) ? RW'(PACKET_MAX) : run_full;
    ridx_sum = RW'(ridx_q) + run_cap;
  end

  assign start = cmd_pop && (cmd_i.kind == CMD_SERVICE) && !busy_q && (ridx_q != widx_q);

  assign out_fire = out_v_q && out_ch.ready;
  assign rd_move  = rd_v_q && (!out_v_q || out_ch.ready);
  assign issue    = (remain_q != '0) && (!rd_v_q || rd_move);

  always_comb begin
    widx_d   = widx_q;
    ridx_d   = ridx_q;
    raddr_d  = raddr_q;
    busy_d   = busy_q;
    remain_d = remain_q;
    len_d    = len_q;
    if (do_push) begin
      widx_d = (widx_q == LAST_IDX) ? '0 : widx_q + 1'b1;
    end
    if (cmd_pop && (cmd_i.kind == CMD_DONE)) begin
      busy_d = 1'b0;
    end
    if (start) begin
      busy_d   = 1'b1;
      remain_d = LEN_W'(run_cap);
      len_d    = LEN_W'(run_cap);
      raddr_d  = ridx_q;
      ridx_d   = (ridx_sum == RW'(FIFO_DEPTH)) ? '0 : AW'(ridx_sum);
    end
    if (issue) begin
      remain_d = remain_q - 1'b1;
      raddr_d  = raddr_q + 1'b1;
    end
    rd_v_d  = issue ? 1'b1 : (rd_move ? 1'b0 : rd_v_q);
    out_v_d = rd_move ? 1'b1 : (out_fire ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      widx_q   <= '0;
      ridx_q   <= '0;
      busy_q   <= 1'b0;
      remain_q <= '0;
      rd_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      widx_q   <= widx_d;
      ridx_q   <= ridx_d;
      busy_q   <= busy_d;
      remain_q <= remain_d;
      rd_v_q   <= rd_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr_d;
    len_q   <= len_d;
    if (do_push) begin
      mem_q[widx_q] <= cmd_i.data;
    end
    if (issue) begin
      rd_data_q <= mem_q[raddr_q];
      rd_last_q <= (remain_q == LEN_W'(1));
      rd_len_q  <= len_q;
    end
    if (rd_move) begin
      out_byte_q <= rd_data_q;
      out_last_q <= rd_last_q;
      out_len_q  <= rd_len_q;
    end
  end

  assign out_ch.valid         = out_v_q;
  assign out_ch.byte_out      = out_byte_q;
  assign out_ch.packet_length = out_len_q;
  assign out_ch.last          = out_last_q;

  a_remain_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    remain_q <= LEN_W'(PACKET_MAX))
    else $error("drain count above packet size");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ridx_q <= LAST_IDX) && (widx_q <= LAST_IDX))
    else $error("store index out of range");

  a_drain_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (remain_q != '0) |-> busy_q)
    else $error("packet draining without busy set");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy_q && (remain_q != '0))
    else $error("service start did not load a packet");

endmodule

/* design/serial_tx_fifo_packetizer_core.sv */
// Top level of the serial transmit FIFO packetizer.
// Depends on sftp_pkg, sftp_if, sftp_front, sftp_cmd_queue and sftp_back.
//
//   channel | dir | payload                              | handshake
//   in_ch   | in  | mode, data_byte, link_configured     | valid/ready
//   out_ch  | out | byte_out, packet_length, last        | valid/ready
//
// Every accepted item passes the front end in its accepting cycle; a kept one
// takes one slot of the four-entry command queue and can leave it in the next
// cycle at the earliest; the back end takes a push or done when not draining.
// A service that starts a packet of N bytes holds the back end until N store
// reads issue, one per cycle on the single read port unless the output stalls;
// bytes pass the read and output registers and leave one per cycle when taken.
// Reset (rst_ni low, asynchronous) clears the indexes, busy flag, queue and
// output valid; the byte store is not cleared and needs no clearing pass.
// A stalled output holds the back end; the front keeps taking items until
// the queue fills.
module serial_tx_fifo_packetizer_core #(
  parameter int unsigned FIFO_DEPTH = sftp_pkg::FIFO_DEPTH_DEF,
  parameter int unsigned PACKET_MAX = sftp_pkg::PACKET_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sftp_in_if.sink    in_ch,
  sftp_out_if.source out_ch
);
  import sftp_pkg::*;

  // Front to queue: classified commands, unlinked pushes already dropped.
  cmd_t fq_cmd;
  logic fq_valid, fq_ready;

  // Queue to back: commands in arrival order.
  cmd_t qb_cmd;
  logic qb_valid, qb_ready;

  sftp_front u_front (
    .in_ch       (in_ch),
    .cmd_o       (fq_cmd),
    .cmd_valid_o (fq_valid),
    .cmd_ready_i (fq_ready)
  );

  // Hold commands here while the back end drains a packet.
  sftp_cmd_queue u_cmd_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_cmd_i   (fq_cmd),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .rd_cmd_o   (qb_cmd),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready)
  );

  // Store bytes, advance indexes and stream packets to the endpoint.
  sftp_back #(
    .FIFO_DEPTH (FIFO_DEPTH),
    .PACKET_MAX (PACKET_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (qb_cmd),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .out_ch      (out_ch)
  );

endmodule

/* test/tb_top.sv */
// Self-checking testbench for serial_tx_fifo_packetizer_core.
// Depends on sftp_pkg, sftp_if and the block's RTL. A scoreboard class
// predicts the packet bytes, and plain tasks drive the input channel.
module tb_top;
  import sftp_pkg::*;

  localparam int unsigned FIFO_DEPTH   = FIFO_DEPTH_DEF;
  localparam int unsigned PACKET_MAX   = PACKET_MAX_DEF;
  localparam int unsigned CLK_PERIOD   = 8;
  localparam int unsigned RESET_CYCLES = 7;
  localparam int unsigned LIMIT_CYCLES = 400_000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 30;

  // Mode code that the block must ignore.
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
    logic              last;
  } pkt_byte_t;

  // Mirror of the FIFO and its indexes; turns every accepted transfer into
  // the packet bytes that it releases, and checks bytes as they leave.
  class packet_ledger;
    bit [BYTE_W-1:0] store [FIFO_DEPTH];
    int unsigned     wr_idx = 0;
    int unsigned     rd_idx = 0;
    bit              busy = 1'b0;
    pkt_byte_t       pending_bytes [$];
    int unsigned     errors = 0;
    int unsigned     checked = 0;
    int unsigned     packets = 0;

    function void take_item(logic [MODE_W-1:0] m, logic [BYTE_W-1:0] d, logic l);
      int unsigned run;
      pkt_byte_t   pb;
      case (m)
        MODE_PUSH: begin
          if (l) begin
            store[wr_idx] = d;
            wr_idx = (wr_idx + 1) % FIFO_DEPTH;
          end
        end
        MODE_DONE: begin
          busy = 1'b0;
        end
        MODE_SERVICE: begin
          if (!busy && rd_idx != wr_idx) begin
            // Take the contiguous run only: stop at the end of the store.
            run = (rd_idx > wr_idx) ? FIFO_DEPTH - rd_idx : wr_idx - rd_idx;
            if (run > PACKET_MAX) run = PACKET_MAX;
            for (int unsigned k = 0; k < run; k++) begin
              pb.data = store[rd_idx + k];
              pb.len  = LEN_W'(run);
              pb.last = (k + 1 == run);
              pending_bytes.push_back(pb);
            end
            rd_idx = (rd_idx + run) % FIFO_DEPTH;
            busy = 1'b1;
            packets++;
          end
        end
        default: ;
      endcase
    endfunction

    function void check_byte(logic [BYTE_W-1:0] b, logic [LEN_W-1:0] len, logic lst);
      pkt_byte_t want;
      if (pending_bytes.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("%0t: unexpected byte: expected none, actual %h len %0d last %b",
                   $time, b, len, lst);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (b !== want.data) begin
        if (errors < MAX_REPORTS)
          $display("%0t: byte_out mismatch: expected %h, actual %h", $time, want.data, b);
        errors++;
      end
      if (len !== want.len) begin
        if (errors < MAX_REPORTS)
          $display("%0t: packet_length mismatch: expected %0d, actual %0d",
                   $time, want.len, len);
        errors++;
      end
      if (lst !== want.last) begin
        if (errors < MAX_REPORTS)
          $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, lst);
        errors++;
      end
      checked++;
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sftp_in_if  in_ch ();
  sftp_out_if out_ch ();

  packet_ledger ledger = new;

  int unsigned items_sent  = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  serial_tx_fifo_packetizer_core #(
    .FIFO_DEPTH(FIFO_DEPTH),
    .PACKET_MAX(PACKET_MAX)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #(CLK_PERIOD * LIMIT_CYCLES);
    $display("%0t: timeout, %0d bytes still expected", $time, ledger.pending_bytes.size());
    $display("status: fail");
    $finish;
  end

  // Offer one item, idling first at the current sender rate, and hold it
  // until the block takes it. Valid stays high into the next item when no
  // idle cycle falls in between, so it is never lowered and raised in one step.
  task automatic send_item(input logic [MODE_W-1:0] m, input logic [BYTE_W-1:0] d,
                           input logic l);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid           <= 1'b1;
    in_ch.mode            <= m;
    in_ch.data_byte       <= d;
    in_ch.link_configured <= l;
    @(posedge clk_i);
    while (in_ch.ready !== 1'b1) @(posedge clk_i);
    // Transfer happened at this edge: update the prediction.
    ledger.take_item(m, d, l);
    // Ignored items do not count toward the stimulus size.
    if (m != MODE_UNUSED && !(m == MODE_PUSH && !l)) items_sent++;
  endtask

  task automatic push_bytes(input int unsigned n);
    repeat (n) send_item(MODE_PUSH, BYTE_W'($urandom_range(0, 255)), 1'b1);
  endtask

  // Mostly well-formed exchanges (a burst of pushes, a service, a done) with
  // random content; the rest is noise over every mode and link state.
  task automatic run_traffic(input int unsigned target);
    int unsigned start;
    int unsigned burst;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 99) < 75) begin
        // Occasional long burst so the run is capped at the packet size.
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(PACKET_MAX - 4, PACKET_MAX + 16)
                                            : $urandom_range(1, 16);
        push_bytes(burst);
        send_item(MODE_SERVICE, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
          send_item(MODE_SERVICE, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) == 0)
          send_item(MODE_PUSH, BYTE_W'($urandom_range(0, 255)), 1'b1);
        send_item(MODE_DONE, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        send_item(MODE_W'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Receiver: decide ready each cycle, check every byte transfer, and once
  // stall for a long stretch in the middle of a packet so the back end
  // stops and the command queue fills behind it.
  initial begin : rx_side
    int unsigned hold_left;
    int unsigned bytes_seen;
    bit          held_once;
    hold_left  = 0;
    bytes_seen = 0;
    held_once  = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        ledger.check_byte(out_ch.byte_out, out_ch.packet_length, out_ch.last);
        bytes_seen++;
      end
      if (!held_once && bytes_seen >= 20 && out_ch.valid === 1'b1 && out_ch.last === 1'b0) begin
        hold_left = HOLD_CYCLES;
        held_once = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    in_ch.valid           <= 1'b0;
    in_ch.mode            <= MODE_PUSH;
    in_ch.data_byte       <= '0;
    in_ch.link_configured <= 1'b0;
    rst_ni                <= 1'b0;
    tx_idle_pct = 11;
    rx_idle_pct = 65;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty service, stray done, unused mode, dropped push,
    // byte extremes, service while busy, push while busy.
    send_item(MODE_SERVICE, 8'h00, 1'b1);
    send_item(MODE_DONE,    8'hff, 1'b0);
    send_item(MODE_UNUSED,  8'hff, 1'b1);
    send_item(MODE_PUSH,    8'hff, 1'b0);
    send_item(MODE_PUSH,    8'h00, 1'b1);
    send_item(MODE_PUSH,    8'hff, 1'b1);
    send_item(MODE_PUSH,    8'ha5, 1'b1);
    send_item(MODE_SERVICE, 8'h00, 1'b0);
    send_item(MODE_SERVICE, 8'hff, 1'b1);
    send_item(MODE_PUSH,    8'h5a, 1'b1);
    send_item(MODE_PUSH,    8'h3c, 1'b0);
    send_item(MODE_DONE,    8'h00, 1'b1);
    send_item(MODE_SERVICE, 8'h00, 1'b1);
    send_item(MODE_DONE,    8'h00, 1'b0);
    send_item(MODE_SERVICE, 8'hff, 1'b0);
    send_item(MODE_UNUSED,  8'h00, 1'b0);

    // Sender seldom idles, receiver often.
    run_traffic(65);

    // Receiver seldom idles, sender often.
    tx_idle_pct = 65;
    rx_idle_pct = 11;
    run_traffic(65);

    // Full rate on both sides.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_traffic(65);

    in_ch.valid <= 1'b0;

    // Let the last packets drain, then watch for stray bytes.
    while (ledger.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d transfers in, %0d packets, %0d packet bytes checked",
             items_sent, ledger.packets, ledger.checked);
    $display("idle mixes on both sides and one long output stall; %0d mismatches",
             ledger.errors);
    if (ledger.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
